// ===== rtl/core/fabik_pkg.sv =====
// Shared types and constants of the inverse-kinematics chain solver.
`default_nettype none
package fabik_pkg;
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_SOLVE = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam logic [5:0] ITER_RESET = 6'd10;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_PIN,
        S_RD_ANCHOR,
        S_RD_POINT,
        S_LOAD,
        S_SQ,
        S_SQRT,
        S_SHIFT,
        S_MUL,
        S_DIV,
        S_APPLY,
        S_WRITE,
        S_EMIT_RD,
        S_EMIT,
        S_SINGLE
    } t_state;

    // Request and reply between the sequencer and the pull arithmetic unit.
    typedef struct packed {
        logic        start;
        logic [95:0] point;
        logic [95:0] anchor;
        logic [30:0] len;
    } t_pull_req;

    typedef struct packed {
        logic        done;
        logic [95:0] point;
    } t_pull_rsp;
endpackage
`default_nettype wire

// ===== rtl/core/fabik_pull.sv =====
// Pull unit: moves one point onto a segment length from its anchor.
`default_nettype none
module fabik_pull (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire fabik_pkg::t_pull_req i_req,
    output fabik_pkg::t_pull_rsp      o_rsp
);
    import fabik_pkg::*;

    typedef enum logic [2:0] {
        P_IDLE, P_DIFF, P_SQ, P_SQRT, P_MUL, P_DIV, P_APPLY
    } t_pst;

    t_pst               r_st;
    logic signed [32:0] r_d [3];
    logic        [32:0] r_m [3];
    logic               r_s;
    logic        [1:0]  r_k;
    logic        [65:0] r_sum;
    logic        [63:0] r_rem;
    logic        [31:0] r_root;
    logic        [5:0]  r_cnt;
    logic        [32:0] r_dist;
    logic        [63:0] r_num;
    logic        [63:0] r_quo;
    logic        [64:0] r_drem;
    logic signed [31:0] r_a [3];
    logic signed [31:0] r_p [3];
    logic        [30:0] r_len;
    logic               r_done;

    logic [31:0] v_sh;
    logic [63:0] v_sq;
    logic [65:0] v_trial;
    logic [65:0] v_rem2;
    logic [64:0] v_dtrial;
    logic [34:0] v_q;
    logic signed [36:0] v_r;

    always_comb begin
        v_sh  = r_s ? r_m[r_k][32:1] : r_m[r_k][31:0];
        v_sq  = v_sh * v_sh;
        // One result bit per cycle of the restoring square root.
        v_rem2   = {r_rem, r_sum[65:64]};
        v_trial  = 66'({r_root, 2'b01});
        v_dtrial = {r_drem[63:0], r_num[63]};
        v_q   = (r_quo > 64'h4_0000_0000) ? 35'h4_0000_0000 : r_quo[34:0];
        v_r   = r_d[r_k][32] ? 37'(r_a[r_k]) - 37'(v_q) : 37'(r_a[r_k]) + 37'(v_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= P_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                P_IDLE: begin
                    if (i_req.start) begin
                        for (int k = 0; k < 3; k++) begin
                            r_p[k] <= i_req.point[32*k +: 32];
                            r_a[k] <= i_req.anchor[32*k +: 32];
                        end
                        r_len <= i_req.len;
                        r_st  <= P_DIFF;
                    end
                end
                P_DIFF: begin
                    for (int k = 0; k < 3; k++) begin
                        r_d[k] <= 33'(r_p[k]) - 33'(r_a[k]);
                    end
                    r_st <= P_SQ;
                    r_k  <= 2'd0;
                    r_sum <= '0;
                    r_s  <= 1'b0;
                    r_cnt <= 6'd0;
                end
                P_SQ: begin
                    // First cycle after DIFF fills magnitudes; later ones square.
                    if (r_k == 2'd0 && r_sum == '0 && !r_s && r_cnt != 6'd63) begin
                        for (int k = 0; k < 3; k++) begin
                            r_m[k] <= r_d[k][32] ? 33'(-r_d[k]) : 33'(r_d[k]);
                            if ((r_d[k][32] ? 33'(-r_d[k]) : 33'(r_d[k])) >= 33'h8000_0000)
                                r_s <= 1'b1;
                        end
                        r_cnt <= 6'd63;
                    end else begin
                        r_sum <= r_sum + 66'(v_sq);
                        if (r_k == 2'd2) begin
                            r_st   <= P_SQRT;
                            r_cnt  <= 6'd0;
                            r_rem  <= '0;
                            r_root <= '0;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end
                end
                P_SQRT: begin
                    if (v_rem2 >= v_trial) begin
                        r_rem  <= 64'(v_rem2 - v_trial);
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= v_rem2[63:0];
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_sum <= {r_sum[63:0], 2'b00};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd32) begin
                        r_st <= P_MUL;
                        r_k  <= 2'd0;
                    end
                end
                P_MUL: begin
                    r_dist <= {r_root, 1'b0} >> !r_s;
                    if (r_root == '0) begin
                        r_st   <= P_IDLE;
                        r_done <= 1'b1;
                    end else begin
                        r_num  <= r_m[r_k] * {2'b0, r_len} +
                                  64'(({r_root, 1'b0} >> !r_s) >> 1);
                        r_quo  <= '0;
                        r_drem <= '0;
                        r_cnt  <= 6'd0;
                        r_st   <= P_DIV;
                    end
                end
                P_DIV: begin
                    if (v_dtrial >= 65'(r_dist)) begin
                        r_drem <= v_dtrial - 65'(r_dist);
                        r_quo  <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_drem <= v_dtrial;
                        r_quo  <= {r_quo[62:0], 1'b0};
                    end
                    r_num <= {r_num[62:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) r_st <= P_APPLY;
                end
                P_APPLY: begin
                    if (v_r > 37'sd2147483647)       r_p[r_k] <= 32'sh7FFF_FFFF;
                    else if (v_r < -37'sd2147483648) r_p[r_k] <= 32'sh8000_0000;
                    else                              r_p[r_k] <= v_r[31:0];
                    if (r_k == 2'd2) begin
                        r_st   <= P_IDLE;
                        r_done <= 1'b1;
                    end else begin
                        r_k  <= r_k + 2'd1;
                        r_st <= P_MUL;
                    end
                end
                default: r_st <= P_IDLE;
            endcase
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.point = {r_p[2], r_p[1], r_p[0]};
endmodule
`default_nettype wire

// ===== rtl/core/fabrik_ik_chain_solver.sv =====
// Top level of the inverse-kinematics chain solver: sequencer and joint memory.
`default_nettype none
// Clear and add each give one transfer. Solve runs iteration_count pass pairs,
// each a backward and a forward pass, through the shared pull unit, which
// takes a root and, unless it is zero, three divides per segment; after that
// each joint is read from the joint memory and reported in index order, one
// transfer per joint with o_last on the final (an empty chain gives one
// ST_EMPTY transfer). One item is in work at a time.
module fabrik_ik_chain_solver #(
    parameter int MAX_JOINTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [31:0] i_point_x,
    input  wire logic [31:0] i_point_y,
    input  wire logic [31:0] i_point_z,
    input  wire logic [31:0] i_goal_x,
    input  wire logic [31:0] i_goal_y,
    input  wire logic [31:0] i_goal_z,
    input  wire logic [30:0] i_segment_length,
    input  wire logic        i_cfg_we,
    input  wire logic [5:0]  i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [3:0]       o_joint_index,
    output logic [31:0]      o_out_x,
    output logic [31:0]      o_out_y,
    output logic [31:0]      o_out_z,
    output logic             o_last
);
    import fabik_pkg::*;

    localparam int AW = $clog2(MAX_JOINTS);
    localparam int CW = $clog2(MAX_JOINTS + 1);

    logic [95:0] r_pos_mem [MAX_JOINTS];
    logic [30:0] r_len_mem [MAX_JOINTS];
    logic [95:0] r_pos_rd;
    logic [30:0] r_len_rd;

    t_state      r_state, n_state;
    logic [5:0]  r_iter_cfg;
    logic [CW-1:0] r_total, n_total;
    logic [5:0]  r_it, n_it;
    logic        r_fwd, n_fwd;
    logic [AW-1:0] r_idx, n_idx;
    logic [95:0] r_origin, r_goal, n_origin, n_goal;
    logic [95:0] r_anchor, n_anchor;
    logic [30:0] r_len, n_len;
    logic        r_ovalid, n_ovalid;
    logic [1:0]  r_status, n_status;
    logic [3:0]  r_oidx, n_oidx;
    logic [95:0] r_opos, n_opos;
    logic        r_olast, n_olast;

    logic          v_we;
    logic [AW-1:0] v_waddr, v_raddr;
    logic [95:0]   v_wpos;
    logic          v_wlen_en;
    t_pull_req     v_req;
    t_pull_rsp     v_rsp;
    logic          v_accept;
    logic [AW-1:0] v_next;

    fabik_pull u_pull (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (v_req),
        .o_rsp  (v_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_pos_mem[v_waddr] <= v_wpos;
            if (v_wlen_en) r_len_mem[v_waddr] <= i_segment_length;
        end
        r_pos_rd <= r_pos_mem[v_raddr];
        r_len_rd <= r_len_mem[v_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_iter_cfg <= ITER_RESET;
            r_total    <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) r_iter_cfg <= i_cfg_data;
        end
        r_it     <= n_it;
        r_fwd    <= n_fwd;
        r_idx    <= n_idx;
        r_origin <= n_origin;
        r_goal   <= n_goal;
        r_anchor <= n_anchor;
        r_len    <= n_len;
        r_status <= n_status;
        r_oidx   <= n_oidx;
        r_opos   <= n_opos;
        r_olast  <= n_olast;
    end

    assign v_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE) || r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_total  = r_total;
        n_it     = r_it;
        n_fwd    = r_fwd;
        n_idx    = r_idx;
        n_origin = r_origin;
        n_goal   = r_goal;
        n_anchor = r_anchor;
        n_len    = r_len;
        n_ovalid = r_ovalid && i_stall;
        n_status = r_status;
        n_oidx   = r_oidx;
        n_opos   = r_opos;
        n_olast  = r_olast;
        v_we      = 1'b0;
        v_wlen_en = 1'b0;
        v_waddr   = r_idx;
        v_wpos    = v_rsp.point;
        v_raddr   = r_idx;
        v_req.start  = 1'b0;
        v_req.point  = r_pos_rd;
        v_req.anchor = r_anchor;
        v_req.len    = r_len;
        v_next = r_fwd ? r_idx + AW'(1) : r_idx - AW'(1);

        case (r_state)
            S_IDLE: begin
                if (v_accept) begin
                    n_origin = {i_point_z, i_point_y, i_point_x};
                    n_goal   = {i_goal_z, i_goal_y, i_goal_x};
                    n_status = ST_OK;
                    n_oidx   = '0;
                    n_opos   = '0;
                    n_olast  = 1'b1;
                    case (t_cmd'(i_cmd))
                        CMD_CLEAR: begin
                            n_total = '0;
                            n_state = S_SINGLE;
                        end
                        CMD_ADD: begin
                            if (r_total >= CW'(MAX_JOINTS)) begin
                                n_status = ST_FULL;
                            end else begin
                                v_we      = 1'b1;
                                v_wlen_en = 1'b1;
                                v_waddr   = r_total[AW-1:0];
                                v_wpos    = {i_point_z, i_point_y, i_point_x};
                                n_opos    = v_wpos;
                                n_oidx    = 4'(r_total);
                                n_total   = r_total + CW'(1);
                            end
                            n_state = S_SINGLE;
                        end
                        CMD_SOLVE: begin
                            if (r_total == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_SINGLE;
                            end else begin
                                n_it    = '0;
                                n_state = S_PIN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SINGLE: begin
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            S_PIN: begin
                if (r_it == r_iter_cfg || r_total == CW'(1)) begin
                    if (r_it != r_iter_cfg) begin
                        // Single joint: each pass pair leaves it at the origin.
                        v_we    = 1'b1;
                        v_waddr = '0;
                        v_wpos  = r_origin;
                    end
                    n_idx   = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    // Backward pass: last joint goes to the goal.
                    v_we     = 1'b1;
                    v_waddr  = AW'(r_total - CW'(1));
                    v_wpos   = r_goal;
                    n_anchor = r_goal;
                    n_idx    = AW'(r_total - CW'(2));
                    n_fwd    = 1'b0;
                    n_state  = S_RD_POINT;
                end
            end
            S_RD_POINT: begin
                v_raddr = r_idx;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // Read data is valid now; the segment length follows the lower joint.
                n_len = r_fwd ? r_len : r_len_rd;
                if (r_fwd) begin
                    v_req.len = r_len;
                end else begin
                    v_req.len = r_len_rd;
                end
                v_req.start = 1'b1;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (v_rsp.done) begin
                    v_we     = 1'b1;
                    v_waddr  = r_idx;
                    v_wpos   = v_rsp.point;
                    n_anchor = v_rsp.point;
                    if (!r_fwd && r_idx == '0) begin
                        // Forward pass: first joint goes to the origin.
                        v_wpos   = r_origin;
                        n_anchor = r_origin;
                        n_fwd    = 1'b1;
                        n_idx    = AW'(1);
                        v_raddr  = '0;
                        n_state  = S_RD_ANCHOR;
                    end else if (r_fwd && CW'(r_idx) == r_total - CW'(1)) begin
                        n_it    = r_it + 6'd1;
                        n_state = S_PIN;
                    end else if (r_fwd) begin
                        v_raddr = r_idx;
                        n_idx   = v_next;
                        n_state = S_RD_ANCHOR;
                    end else begin
                        n_idx   = v_next;
                        n_state = S_RD_POINT;
                    end
                end
            end
            S_RD_ANCHOR: begin
                // Length of the segment below the point being moved.
                n_len   = r_len_rd;
                v_raddr = r_idx;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                v_req.start = 1'b1;
                v_req.len   = r_len;
                n_state     = S_SQRT;
            end
            S_EMIT_RD: begin
                v_raddr = r_idx;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_status = ST_OK;
                    n_oidx   = 4'(r_idx);
                    n_opos   = r_pos_rd;
                    n_olast  = (CW'(r_idx) == r_total - CW'(1));
                    if (n_olast) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_status;
    assign o_joint_index = r_oidx;
    assign o_out_x       = r_opos[31:0];
    assign o_out_y       = r_opos[63:32];
    assign o_out_z       = r_opos[95:64];
    assign o_last        = r_olast;
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench of the inverse-kinematics chain solver.
`timescale 1ns / 1ps

module tb;
    import fabik_pkg::*;

    typedef struct {
        t_cmd        cmd;
        logic [31:0] px, py, pz, gx, gy, gz;
        logic [30:0] len;
    } t_item;

    typedef struct {
        t_status     status;
        logic [3:0]  idx;
        logic [31:0] x, y, z;
        logic        last;
    } t_joint_rpt;

    localparam int NJ = 16;
    localparam int CYCLE_LIMIT = 5_000_000;

    logic        i_clk, i_rst_n, i_valid, i_stall, i_cfg_we;
    logic [1:0]  i_cmd;
    logic [31:0] i_point_x, i_point_y, i_point_z, i_goal_x, i_goal_y, i_goal_z;
    logic [30:0] i_segment_length;
    logic [5:0]  i_cfg_data;
    logic        o_stall, o_valid, o_last;
    logic [1:0]  o_status;
    logic [3:0]  o_joint_index;
    logic [31:0] o_out_x, o_out_y, o_out_z;

    fabrik_ik_chain_solver u_top (.*);

    t_item             pending_items[$];
    t_joint_rpt        expected_rpts[$];
    t_item             cur_item;
    int                send_idle_pct, recv_stall_pct, errors, cycles;

    // Predictor state.
    logic signed [31:0] jpos[NJ][3];
    logic [30:0]        jlen[NJ];
    int                 chain_len;
    logic [5:0]         pass_pairs;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [63:0] root64(logic [63:0] n);
        logic [63:0] res, b;
        res = 0;
        b = 64'h1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Moves joint mi onto the sphere of radius len round joint ai.
    task automatic pull_joint(int mi, int ai, logic [30:0] len);
        longint      d[3];
        logic [63:0] mag[3];
        logic [63:0] sum, seg_dist, q;
        longint      off, r;
        int          s;
        s = 0;
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            d[k] = longint'(jpos[mi][k]) - longint'(jpos[ai][k]);
            mag[k] = d[k] < 0 ? -d[k] : d[k];
            if (mag[k] >= 64'h8000_0000) s = 1;
        end
        for (int k = 0; k < 3; k++) sum += (mag[k] >> s) * (mag[k] >> s);
        seg_dist = root64(sum) << s;
        if (seg_dist == 0) return;
        for (int k = 0; k < 3; k++) begin
            q = (mag[k] * {33'b0, len} + seg_dist / 2) / seg_dist;
            if (q > (64'h1 << 34)) q = 64'h1 << 34;
            off = d[k] < 0 ? -longint'(q) : longint'(q);
            r = longint'(jpos[ai][k]) + off;
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            jpos[mi][k] = r[31:0];
        end
    endtask

    task automatic push_rpt(t_status st, int idx, logic [31:0] x, y, z, logic last);
        t_joint_rpt e;
        e.status = st; e.idx = idx[3:0]; e.x = x; e.y = y; e.z = z; e.last = last;
        expected_rpts.push_back(e);
    endtask

    task automatic predict_chain(t_item it);
        case (it.cmd)
            CMD_CLEAR: begin
                chain_len = 0;
                push_rpt(ST_OK, 0, 0, 0, 0, 1);
            end
            CMD_ADD: begin
                if (chain_len >= NJ) begin
                    push_rpt(ST_FULL, 0, 0, 0, 0, 1);
                end else begin
                    jpos[chain_len] = '{it.px, it.py, it.pz};
                    jlen[chain_len] = it.len;
                    push_rpt(ST_OK, chain_len, it.px, it.py, it.pz, 1);
                    chain_len++;
                end
            end
            CMD_SOLVE: begin
                if (chain_len == 0) begin
                    push_rpt(ST_EMPTY, 0, 0, 0, 0, 1);
                end else begin
                    for (int p = 0; p < pass_pairs; p++) begin
                        jpos[chain_len-1] = '{it.gx, it.gy, it.gz};
                        for (int i = chain_len - 1; i > 0; i--)
                            pull_joint(i - 1, i, jlen[i-1]);
                        jpos[0] = '{it.px, it.py, it.pz};
                        for (int i = 0; i + 1 < chain_len; i++)
                            pull_joint(i + 1, i, jlen[i]);
                    end
                    for (int i = 0; i < chain_len; i++)
                        push_rpt(ST_OK, i, jpos[i][0], jpos[i][1], jpos[i][2],
                                 i + 1 == chain_len);
                end
            end
            default: ;
        endcase
    endtask

    // Driver: one transfer per accepted item; prediction happens on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) predict_chain(cur_item);
            if (!i_valid || !o_stall) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = pending_items.pop_front();
                    i_valid <= 1'b1;
                    i_cmd <= cur_item.cmd;
                    i_point_x <= cur_item.px;
                    i_point_y <= cur_item.py;
                    i_point_z <= cur_item.pz;
                    i_goal_x <= cur_item.gx;
                    i_goal_y <= cur_item.gy;
                    i_goal_z <= cur_item.gz;
                    i_segment_length <= cur_item.len;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_joint_rpt e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("fabrik_ik_chain_solver test failed");
            $finish;
        end
        i_stall <= i_rst_n && ($urandom_range(99) < recv_stall_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rpts.size() == 0) begin
                $display("%0t unexpected result idx %0d", $time, o_joint_index);
                errors++;
            end else begin
                e = expected_rpts.pop_front();
                if (o_status !== e.status) begin
                    $display("%0t status exp %0d got %0d", $time, e.status, o_status);
                    errors++;
                end
                if (o_joint_index !== e.idx) begin
                    $display("%0t index exp %0d got %0d", $time, e.idx, o_joint_index);
                    errors++;
                end
                if (o_out_x !== e.x) begin
                    $display("%0t x exp %h got %h", $time, e.x, o_out_x);
                    errors++;
                end
                if (o_out_y !== e.y) begin
                    $display("%0t y exp %h got %h", $time, e.y, o_out_y);
                    errors++;
                end
                if (o_out_z !== e.z) begin
                    $display("%0t z exp %h got %h", $time, e.z, o_out_z);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $display("%0t last exp %0d got %0d", $time, e.last, o_last);
                    errors++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(7))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom_range(200 << 16) - (100 << 16);
        endcase
    endfunction

    function automatic logic [30:0] rand_len();
        case ($urandom_range(5))
            0: return 31'($urandom);
            1: return 31'h7fff_ffff;
            default: return 31'($urandom_range(50 << 16));
        endcase
    endfunction

    task automatic queue_item(t_cmd c, logic [31:0] px, py, pz, gx, gy, gz,
                              logic [30:0] len);
        t_item it;
        it.cmd = c; it.px = px; it.py = py; it.pz = pz;
        it.gx = gx; it.gy = gy; it.gz = gz; it.len = len;
        pending_items.push_back(it);
    endtask

    task automatic queue_random(t_cmd c);
        queue_item(c, rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord(), rand_len());
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || i_valid || expected_rpts.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_passes(logic [5:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pass_pairs = v;
    endtask

    initial begin
        logic [5:0] pass_set[8];
        logic [31:0] p5;
        int n_len, cap;
        pass_set = '{6'd1, 6'd63, 6'd0, 6'd2, 6'd3, 6'd1, 6'd2, 6'd5};
        errors = 0; cycles = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        i_rst_n = 0; i_valid = 0; i_stall = 0; i_cfg_we = 0; i_cfg_data = 0;
        i_cmd = CMD_CLEAR; i_segment_length = 0;
        i_point_x = 0; i_point_y = 0; i_point_z = 0;
        i_goal_x = 0; i_goal_y = 0; i_goal_z = 0;
        chain_len = 0; pass_pairs = ITER_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, under the reset pass count.
        p5 = 32'd5 << 16;
        queue_item(CMD_NONE, 1, 2, 3, 4, 5, 6, 7);
        queue_item(CMD_SOLVE, 0, 0, 0, 0, 0, 0, 0);
        queue_item(CMD_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0,
                   31'h7fff_ffff);
        queue_item(CMD_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0);
        queue_item(CMD_SOLVE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
        queue_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        // Coincident joints and goal give zero distances.
        queue_item(CMD_ADD, p5, p5, p5, 0, 0, 0, 31'd3 << 16);
        queue_item(CMD_ADD, p5, p5, p5, 0, 0, 0, 31'd1 << 16);
        queue_item(CMD_SOLVE, p5, p5, p5, p5, p5, p5, 0);
        queue_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < NJ + 1; i++) queue_random(CMD_ADD);
        queue_random(CMD_SOLVE);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_passes(pass_set[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            cap = pass_pairs > 10 ? 2 : 6;
            queue_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
            n_len = 0;
            for (int i = 0; i < 9; i++) begin
                case ($urandom_range(19))
                    0, 1: begin queue_random(CMD_CLEAR); n_len = 0; end
                    2: queue_random(CMD_NONE);
                    3, 4, 5, 6, 7, 8: queue_random(CMD_SOLVE);
                    default: begin
                        if (n_len < cap) begin
                            queue_random(CMD_ADD);
                            n_len++;
                        end else begin
                            queue_random(CMD_SOLVE);
                        end
                    end
                endcase
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("fabrik_ik_chain_solver test passed");
        else
            $display("fabrik_ik_chain_solver test failed");
        $finish;
    end
endmodule
